// File: rtl/core/ada_pkg.sv
// Shared types and codes for the array descriptor allocator.
package ada_pkg;

  localparam int REQ_W      = 2;
  localparam int LETTER_W   = 5;
  localparam int VALUE_W    = 16;
  localparam int DIMS_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int ADDR_OUT_W = 12;

  localparam logic [REQ_W-1:0] REQ_DECLARE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ACCESS  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  localparam logic [DIMS_W-1:0] DIMS_ONE = 2'd1;
  localparam logic [DIMS_W-1:0] DIMS_TWO = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_REDECL    = 3'd1,
    ST_BOUND_LOW = 3'd2,
    ST_NO_ROOM   = 3'd3,
    ST_DIM       = 3'd4,
    ST_RANGE     = 3'd5
  } status_e;

endpackage

// File: rtl/core/array_descriptor_allocator.sv
// Array descriptor allocator: descriptor table, bump pool and one-pass request datapath.
// An accepted beat is held in the input register, then its result in the result register.
// Throughput: one request per cycle unless out_ready_i stalls the result register;
//   the table read, the two multipliers and the pool compare all sit between these registers.
// Reset (async, active low): all slots undeclared, pool empty, base_index 0,
//   both pipeline registers empty. A clear request empties table and pool in one beat.
module array_descriptor_allocator #(
  parameter int ARRAY_SLOTS   = 32,
  parameter int POOL_WORDS    = 4096,
  parameter int DEFAULT_BOUND = 10
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ada_pkg::REQ_W-1:0]          req_type_i,
  input  logic [ada_pkg::LETTER_W-1:0]       letter_i,
  input  logic signed [ada_pkg::VALUE_W-1:0] first_value_i,
  input  logic signed [ada_pkg::VALUE_W-1:0] second_value_i,
  input  logic [ada_pkg::DIMS_W-1:0]         dimensions_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ada_pkg::STATUS_W-1:0]       status_o,
  output logic [ada_pkg::ADDR_OUT_W-1:0]     element_address_o
);

  localparam int SLOT_W  = (ARRAY_SLOTS > 1) ? $clog2(ARRAY_SLOTS) : 1;
  localparam int LX_W    = 9;
  localparam int BND_W   = $clog2(POOL_WORDS);
  localparam int UW      = $clog2(POOL_WORDS + 1);
  localparam int CMP_W   = (UW + 1 > ada_pkg::VALUE_W + 1) ? UW + 1 : ada_pkg::VALUE_W + 1;
  localparam int CNT_W   = 2 * UW;
  localparam int IDX_W   = BND_W + UW;

  localparam logic [LX_W-1:0]         SLOTS_L = LX_W'(ARRAY_SLOTS);
  localparam logic signed [CMP_W-1:0] POOL_S  = CMP_W'(POOL_WORDS);
  localparam logic signed [CMP_W-1:0] DEF_S   = CMP_W'(DEFAULT_BOUND);
  localparam logic signed [CMP_W-1:0] ONE_S   = CMP_W'(1);
  localparam logic [CNT_W:0]          POOL_L  = (CNT_W + 1)'(POOL_WORDS);

  // input register
  logic                               in_valid_q;
  logic [ada_pkg::REQ_W-1:0]          req_q;
  logic [ada_pkg::LETTER_W-1:0]       letter_q;
  logic signed [ada_pkg::VALUE_W-1:0] v1_q;
  logic signed [ada_pkg::VALUE_W-1:0] v2_q;
  logic [ada_pkg::DIMS_W-1:0]         dims_q;

  // result register
  logic                               out_valid_q;
  ada_pkg::status_e                   status_q;
  logic [ada_pkg::ADDR_OUT_W-1:0]     addr_q;

  // state
  logic                               base_q;
  logic [UW-1:0]                      pool_used_q;
  logic [ARRAY_SLOTS-1:0]             decl_q;
  logic [BND_W-1:0]                   off_q [ARRAY_SLOTS];
  logic [BND_W-1:0]                   b1_q  [ARRAY_SLOTS];
  logic [BND_W-1:0]                   b2_q  [ARRAY_SLOTS];
  logic [ARRAY_SLOTS-1:0]             two_q;

  logic adv;
  logic accept;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  // datapath
  logic                      dims_ok;
  logic                      two;
  logic [LX_W-1:0]           letter_x;
  logic                      slot_ok;
  logic [SLOT_W-1:0]         slot;
  logic                      rd_decl;
  logic signed [CMP_W-1:0]   base_x;
  logic signed [CMP_W-1:0]   v1_x;
  logic signed [CMP_W-1:0]   v2_x;
  logic signed [CMP_W-1:0]   ab1;
  logic signed [CMP_W-1:0]   ab2;
  logic signed [CMP_W-1:0]   t1;
  logic signed [CMP_W-1:0]   t2;
  logic [UW-1:0]             f1;
  logic [UW-1:0]             f2;
  logic [CNT_W-1:0]          count;
  logic [CNT_W:0]            sum;
  ada_pkg::status_e          alloc_st;
  logic [UW-1:0]             new_used;
  logic [BND_W-1:0]          e_off;
  logic [BND_W-1:0]          e_b1;
  logic [BND_W-1:0]          e_b2;
  logic                      e_two;
  logic signed [CMP_W-1:0]   e_b1_x;
  logic signed [CMP_W-1:0]   e_b2_x;
  logic signed [CMP_W-1:0]   s1;
  logic signed [CMP_W-1:0]   s2;
  logic signed [CMP_W-1:0]   sp;
  logic [UW-1:0]             span;
  logic [IDX_W-1:0]          idx;
  logic [BND_W-1:0]          addr;
  logic [BND_W+ada_pkg::ADDR_OUT_W-1:0] addr_x;
  ada_pkg::status_e          status_d;
  logic [ada_pkg::ADDR_OUT_W-1:0] addr_d;
  logic                      wr_desc;
  logic                      clr;
  logic [UW-1:0]             pool_used_d;

  assign letter_x = {{(LX_W - ada_pkg::LETTER_W){1'b0}}, letter_q};
  assign slot     = letter_x[SLOT_W-1:0];
  assign slot_ok  = letter_x < SLOTS_L;
  assign rd_decl  = slot_ok && decl_q[slot];
  assign dims_ok  = (dims_q == ada_pkg::DIMS_ONE) || (dims_q == ada_pkg::DIMS_TWO);
  assign two      = dims_q == ada_pkg::DIMS_TWO;
  assign base_x   = $signed({{(CMP_W - 1){1'b0}}, base_q});
  assign v1_x     = $signed({{(CMP_W - ada_pkg::VALUE_W){v1_q[ada_pkg::VALUE_W-1]}}, v1_q});
  assign v2_x     = $signed({{(CMP_W - ada_pkg::VALUE_W){v2_q[ada_pkg::VALUE_W-1]}}, v2_q});

  // allocation: explicit bounds on declare, default bounds on auto-declare
  always_comb begin
    if (req_q == ada_pkg::REQ_DECLARE) begin
      ab1 = v1_x;
      ab2 = v2_x;
    end else begin
      ab1 = DEF_S;
      ab2 = DEF_S;
    end
    t1    = ab1 - base_x + ONE_S;
    t2    = ab2 - base_x + ONE_S;
    f1    = t1[UW-1:0];
    f2    = two ? t2[UW-1:0] : UW'(1);
    count = CNT_W'(f1) * CNT_W'(f2);
    sum   = {{(CNT_W + 1 - UW){1'b0}}, pool_used_q} + {1'b0, count};
    new_used = sum[UW-1:0];
    if (ab1 < base_x || (two && ab2 < base_x)) begin
      alloc_st = ada_pkg::ST_BOUND_LOW;
    end else if (ab1 >= POOL_S || (two && ab2 >= POOL_S)) begin
      alloc_st = ada_pkg::ST_NO_ROOM;
    end else if (sum > POOL_L) begin
      alloc_st = ada_pkg::ST_NO_ROOM;
    end else begin
      alloc_st = ada_pkg::ST_OK;
    end
  end

  // effective descriptor: stored one, or the freshly built one
  always_comb begin
    if (rd_decl) begin
      e_off = off_q[slot];
      e_b1  = b1_q[slot];
      e_b2  = b2_q[slot];
      e_two = two_q[slot];
    end else begin
      e_off = pool_used_q[BND_W-1:0];
      e_b1  = ab1[BND_W-1:0];
      e_b2  = two ? ab2[BND_W-1:0] : '0;
      e_two = two;
    end
    e_b1_x = $signed({{(CMP_W - BND_W){1'b0}}, e_b1});
    e_b2_x = $signed({{(CMP_W - BND_W){1'b0}}, e_b2});
    s1     = v1_x - base_x;
    s2     = v2_x - base_x;
    sp     = e_b2_x - base_x + ONE_S;
    span   = sp[UW-1:0];
    if (two) begin
      idx = IDX_W'(s1[BND_W-1:0]) * IDX_W'(span) + IDX_W'(s2[BND_W-1:0]);
    end else begin
      idx = IDX_W'(s1[BND_W-1:0]);
    end
    addr   = e_off + idx[BND_W-1:0];
    addr_x = {{ada_pkg::ADDR_OUT_W{1'b0}}, addr};
  end

  always_comb begin
    status_d    = ada_pkg::ST_OK;
    addr_d      = '0;
    wr_desc     = 1'b0;
    clr         = 1'b0;
    pool_used_d = pool_used_q;
    case (req_q)
      ada_pkg::REQ_DECLARE: begin
        if (!dims_ok) begin
          status_d = ada_pkg::ST_DIM;
        end else if (!slot_ok) begin
          status_d = ada_pkg::ST_RANGE;
        end else if (rd_decl) begin
          status_d = ada_pkg::ST_REDECL;
        end else begin
          status_d = alloc_st;
          if (alloc_st == ada_pkg::ST_OK) begin
            wr_desc     = 1'b1;
            pool_used_d = new_used;
          end
        end
      end
      ada_pkg::REQ_ACCESS: begin
        if (!dims_ok) begin
          status_d = ada_pkg::ST_DIM;
        end else if (!slot_ok) begin
          status_d = ada_pkg::ST_RANGE;
        end else if (!rd_decl && alloc_st != ada_pkg::ST_OK) begin
          status_d = alloc_st;
        end else if (e_two != two) begin
          status_d = ada_pkg::ST_DIM;
        end else if (v1_x < base_x || v1_x > e_b1_x) begin
          status_d = ada_pkg::ST_RANGE;
        end else if (two && (v2_x < base_x || v2_x > e_b2_x)) begin
          status_d = ada_pkg::ST_RANGE;
        end else begin
          addr_d = addr_x[ada_pkg::ADDR_OUT_W-1:0];
          if (!rd_decl) begin
            wr_desc     = 1'b1;
            pool_used_d = new_used;
          end
        end
      end
      ada_pkg::REQ_CLEAR: begin
        clr         = 1'b1;
        pool_used_d = '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= 1'b0;
      pool_used_q <= '0;
      decl_q      <= '0;
    end else begin
      in_valid_q <= (in_valid_q && !adv) || accept;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (adv) begin
        pool_used_q <= pool_used_d;
        if (clr) begin
          decl_q <= '0;
        end else if (wr_desc) begin
          decl_q[slot] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_type_i;
      letter_q <= letter_i;
      v1_q     <= first_value_i;
      v2_q     <= second_value_i;
      dims_q   <= dimensions_i;
    end
    if (adv) begin
      status_q <= status_d;
      addr_q   <= addr_d;
    end
    if (adv && wr_desc) begin
      off_q[slot] <= e_off;
      b1_q[slot]  <= e_b1;
      b2_q[slot]  <= e_b2;
      two_q[slot] <= e_two;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign element_address_o = addr_q;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W + 1)'(pool_used_q) <= POOL_L)
    else $error("pool usage exceeds pool size");

  a_err_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && status_d != ada_pkg::ST_OK) |=> (addr_q == '0))
    else $error("address returned with an error status");

  a_err_keeps_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && status_d != ada_pkg::ST_OK) |=> $stable(pool_used_q))
    else $error("failed request changed the pool");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && req_q == ada_pkg::REQ_CLEAR) |=> (pool_used_q == '0 && decl_q == '0))
    else $error("clear left state behind");

endmodule
